/* sv/first_match_packet_rule_classifier_unit_defines.svh */
// assertion macros used by the checker
`ifndef FIRST_MATCH_PACKET_RULE_CLASSIFIER_UNIT_DEFINES_SVH
`define FIRST_MATCH_PACKET_RULE_CLASSIFIER_UNIT_DEFINES_SVH

// same-cycle implication
`define FCLS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FCLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/fcls_pkg.sv */
package fcls_pkg;

    localparam int RULE_SLOTS = 64;
    localparam int IDX_W      = (RULE_SLOTS > 2) ? $clog2(RULE_SLOTS) : 1;
    localparam int CNT_W      = $clog2(RULE_SLOTS + 1);

    localparam logic [31:0] FULL_MASK  = 32'hffffffff;
    localparam logic [1:0]  DIR_ANY    = 2'd2;
    localparam logic [8:0]  PROTO_ICMP = 9'd1;
    localparam logic [8:0]  PROTO_TCP  = 9'd6;
    localparam logic [8:0]  PROTO_UDP  = 9'd17;
    localparam logic [8:0]  PROTO_ANY  = 9'd256;
    localparam logic [8:0]  PROTO_OTHR = 9'd257;
    localparam logic [15:0] PORT_WILD  = 16'd0;
    localparam logic [15:0] PORT_HIGH  = 16'd1024;
    localparam logic [1:0]  ACK_SET    = 2'd1;
    localparam logic [1:0]  ACK_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        OP_CLASSIFY = 2'd0,
        OP_APPEND   = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        RSN_MATCH    = 3'd0,
        RSN_NOMATCH  = 3'd1,
        RSN_XMAS     = 3'd2,
        RSN_INACTIVE = 3'd3,
        RSN_FULL     = 3'd4
    } t_reason;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [5:0]  src_len;
        logic [5:0]  dst_len;
        logic [1:0]  dir;
        logic [8:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [1:0]  ack;
        logic        act;
    } t_rule;

    typedef struct packed {
        logic [1:0]  dir;
        logic [31:0] src;
        logic [31:0] dst;
        logic [8:0]  cls;
        logic [15:0] sport;
        logic [15:0] dport;
        logic        ack;
    } t_pkt;

    // packet moving down the cell row with its verdict so far
    typedef struct packed {
        logic             vld;
        logic             found;
        logic             acc;
        logic [IDX_W-1:0] idx;
        t_pkt             pkt;
    } t_walk;

endpackage

/* sv/fcls_cell.sv */
module fcls_cell import fcls_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  t_rule            i_rule,
    input  logic             i_live,
    input  logic [IDX_W-1:0] i_idx,
    input  t_walk            i_walk,
    output t_walk            o_walk
);

    t_rule       r_rule;
    logic        r_vld;
    t_walk       r_walk;
    t_walk       n_walk;
    logic [31:0] sm;
    logic [31:0] dm;
    logic        hit;
    logic        l4;
    logic        sp_ok;
    logic        dp_ok;

    // rule storage for this slot
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_rule <= i_rule;
        end
    end

    // match of the passing packet against the held rule
    always_comb begin
        sm    = ~(FULL_MASK >> r_rule.src_len);
        dm    = ~(FULL_MASK >> r_rule.dst_len);
        l4    = (i_walk.pkt.cls == PROTO_TCP) || (i_walk.pkt.cls == PROTO_UDP);
        sp_ok = (r_rule.sport == PORT_WILD) || (i_walk.pkt.sport == r_rule.sport)
              || ((r_rule.sport == PORT_HIGH) && (i_walk.pkt.sport >= PORT_HIGH));
        dp_ok = (r_rule.dport == PORT_WILD) || (i_walk.pkt.dport == r_rule.dport)
              || ((r_rule.dport == PORT_HIGH) && (i_walk.pkt.dport >= PORT_HIGH));
        hit   = ((i_walk.pkt.src & sm) == (r_rule.src & sm))
              && ((i_walk.pkt.dst & dm) == (r_rule.dst & dm))
              && ((i_walk.pkt.dir == r_rule.dir) || (r_rule.dir == DIR_ANY)
                  || (i_walk.pkt.dir == DIR_ANY))
              && ((i_walk.pkt.cls == r_rule.proto) || (r_rule.proto == PROTO_ANY))
              && (!l4 || (sp_ok && dp_ok))
              && !((i_walk.pkt.cls == PROTO_TCP)
                   && (((r_rule.ack == ACK_SET) && !i_walk.pkt.ack)
                       || ((r_rule.ack == ACK_CLEAR) && i_walk.pkt.ack)));
        n_walk = i_walk;
        if (!i_walk.found && i_live && hit) begin
            n_walk.found = 1'b1;
            n_walk.acc   = r_rule.act;
            n_walk.idx   = i_idx;
        end
    end

    // hand the packet to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_walk.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk <= n_walk;
    end

    always_comb begin
        o_walk     = r_walk;
        o_walk.vld = r_vld;
    end

endmodule

/* sv/first_match_packet_rule_classifier_unit.sv */
// channel  | valid   | stall   | payload
// ---------+---------+---------+-------------------------------------------
// in       | i_valid | o_stall | i_opcode .. i_rule_accepts
// out      | o_valid | i_stall | o_accept, o_reason, o_matched_rule, o_rules_held
// config   | i_cfg_we (no stall)| i_cfg_wdata = firewall_active
//
// a classify item walks a row of RULE_SLOTS cells, one cell per cycle; its result
// passes through the cell registers and then the result register before it shows;
// other items show their result the next cycle
// one item is in flight at a time; o_stall is high until its result is taken
// reset clears the rule count and sets firewall_active; rule contents are not reset
// a stalled result holds in the output register
module first_match_packet_rule_classifier_unit import fcls_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [1:0]  i_direction,
    input  logic [31:0] i_source_address,
    input  logic [31:0] i_dest_address,
    input  logic [5:0]  i_source_prefix_len,
    input  logic [5:0]  i_dest_prefix_len,
    input  logic [8:0]  i_protocol,
    input  logic [15:0] i_source_port,
    input  logic [15:0] i_dest_port,
    input  logic [3:0]  i_tcp_flags,
    input  logic [1:0]  i_ack_mode,
    input  logic        i_rule_accepts,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_accept,
    output logic [2:0]  o_reason,
    output logic [5:0]  o_matched_rule,
    output logic [6:0]  o_rules_held
);

    t_state           r_state, n_state;
    logic             r_active;
    logic [CNT_W-1:0] r_total, n_total;
    logic             r_acc, n_acc;
    t_reason          r_rsn, n_rsn;
    logic [5:0]       r_idx, n_idx;
    logic             take;
    logic [8:0]       cls;
    t_walk            chain [RULE_SLOTS+1];
    t_rule            new_rule;
    t_walk            inj;
    t_walk            head;

    assign take = i_valid && (r_state == ST_IDLE);
    assign cls  = ((i_protocol == PROTO_ICMP) || (i_protocol == PROTO_TCP)
                   || (i_protocol == PROTO_UDP)) ? i_protocol : PROTO_OTHR;

    // rule and packet as seen by the cells
    always_comb begin
        new_rule.src     = i_source_address;
        new_rule.dst     = i_dest_address;
        new_rule.src_len = i_source_prefix_len;
        new_rule.dst_len = i_dest_prefix_len;
        new_rule.dir     = i_direction;
        new_rule.proto   = i_protocol;
        new_rule.sport   = i_source_port;
        new_rule.dport   = i_dest_port;
        new_rule.ack     = i_ack_mode;
        new_rule.act     = i_rule_accepts;
        inj.vld          = 1'b0;
        inj.found        = 1'b0;
        inj.acc          = 1'b0;
        inj.idx          = '0;
        inj.pkt.dir      = i_direction;
        inj.pkt.src      = i_source_address;
        inj.pkt.dst      = i_dest_address;
        inj.pkt.cls      = cls;
        inj.pkt.sport    = i_source_port;
        inj.pkt.dport    = i_dest_port;
        inj.pkt.ack      = i_tcp_flags[0];
    end

    // next state, rule count and result
    always_comb begin
        n_state = r_state;
        n_total = r_total;
        n_acc   = r_acc;
        n_rsn   = r_rsn;
        n_idx   = r_idx;
        head    = inj;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_acc   = 1'b0;
                    n_rsn   = RSN_MATCH;
                    n_idx   = '0;
                    n_state = ST_OUT;
                    unique case (t_op'(i_opcode))
                        OP_CLASSIFY: begin
                            if (!r_active) begin
                                n_rsn = RSN_INACTIVE;
                            end else if ((cls == PROTO_TCP)
                                         && (i_tcp_flags[3:1] == 3'b111)) begin
                                n_rsn = RSN_XMAS;
                            end else begin
                                head.vld = 1'b1;
                                n_state  = ST_WALK;
                            end
                        end
                        OP_APPEND: begin
                            if (r_total >= CNT_W'(RULE_SLOTS)) begin
                                n_total = '0;
                                n_rsn   = RSN_FULL;
                            end else begin
                                n_total = r_total + 1'b1;
                            end
                        end
                        OP_CLEAR: n_total = '0;
                        OP_NONE:  n_total = r_total;
                    endcase
                end
            end
            ST_WALK: begin
                if (chain[RULE_SLOTS].vld) begin
                    n_acc   = chain[RULE_SLOTS].found && chain[RULE_SLOTS].acc;
                    n_rsn   = chain[RULE_SLOTS].found ? RSN_MATCH : RSN_NOMATCH;
                    n_idx   = chain[RULE_SLOTS].found ? 6'(chain[RULE_SLOTS].idx) : 6'd0;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign chain[0] = head;

    // row of rule cells
    for (genvar g = 0; g < RULE_SLOTS; g++) begin : g_cell
        fcls_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (take && (t_op'(i_opcode) == OP_APPEND) && (r_total == CNT_W'(g))),
            .i_rule  (new_rule),
            .i_live  (CNT_W'(g) < r_total),
            .i_idx   (IDX_W'(g)),
            .i_walk  (chain[g]),
            .o_walk  (chain[g+1])
        );
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_total  <= '0;
            r_active <= 1'b1;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_rsn <= n_rsn;
        r_idx <= n_idx;
    end

    assign o_stall        = (r_state != ST_IDLE);
    assign o_valid        = (r_state == ST_OUT);
    assign o_accept       = r_acc;
    assign o_reason       = r_rsn;
    assign o_matched_rule = r_idx;
    assign o_rules_held   = 7'(r_total);

endmodule

/* sv/fcls_checker.sv */
`include "first_match_packet_rule_classifier_unit_defines.svh"

module fcls_checker import fcls_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_accept,
    input logic [2:0]  o_reason,
    input logic [5:0]  o_matched_rule,
    input logic [6:0]  o_rules_held
);

    // a result waiting under stall keeps its reason and rule count
    `FCLS_ASSERT_NEXT(a_hold, o_valid && i_stall, o_valid && $stable(o_reason) && $stable(o_rules_held), "stalled result changed")

    // one item at a time: no item taken while a result is shown
    `FCLS_ASSERT_NOW(a_one, i_valid && !o_stall, !o_valid, "item taken while result pending")

    // only a rule match gives accept or a nonzero index
    `FCLS_ASSERT_NOW(a_match, o_valid && (o_accept || (o_matched_rule != 6'd0)), o_reason == RSN_MATCH, "verdict without match")

    // a full-table append leaves the table empty
    `FCLS_ASSERT_NOW(a_full, o_valid && (o_reason == RSN_FULL), o_rules_held == 7'd0, "full append kept rules")

endmodule

bind first_match_packet_rule_classifier_unit fcls_checker u_fcls_checker (.*);

/* tb/sv/first_match_packet_rule_classifier_unit_checker.sv */
`timescale 1ns / 1ps
module first_match_packet_rule_classifier_unit_checker import fcls_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [1:0]  i_opcode,
    input  logic [1:0]  i_direction,
    input  logic [31:0] i_source_address,
    input  logic [31:0] i_dest_address,
    input  logic [5:0]  i_source_prefix_len,
    input  logic [5:0]  i_dest_prefix_len,
    input  logic [8:0]  i_protocol,
    input  logic [15:0] i_source_port,
    input  logic [15:0] i_dest_port,
    input  logic [3:0]  i_tcp_flags,
    input  logic [1:0]  i_ack_mode,
    input  logic        i_rule_accepts,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_accept,
    input  logic [2:0]  i_reason,
    input  logic [5:0]  i_matched_rule,
    input  logic [6:0]  i_rules_held,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic        acc;
        t_reason     rsn;
        logic [5:0]  idx;
        logic [6:0]  held;
    } t_verdict;

    t_rule      rule_table [RULE_SLOTS];
    int         rule_count;
    logic       fw_on;
    t_verdict   verdict_q [$];

    assign o_pending = verdict_q.size();

    function automatic logic [31:0] mask_of(logic [5:0] len);
        if (len == 0) return 32'h0;
        if (len >= 32) return FULL_MASK;
        return FULL_MASK << (32 - len);
    endfunction

    function automatic logic port_pass(logic [15:0] pkt, logic [15:0] rp);
        return rp == PORT_WILD || pkt == rp || (rp == PORT_HIGH && pkt >= PORT_HIGH);
    endfunction

    function automatic logic rule_hit(t_rule r, logic [1:0] dir, logic [31:0] sa,
                                      logic [31:0] da, logic [8:0] cls,
                                      logic [15:0] sp, logic [15:0] dp, logic ack);
        logic [31:0] sm;
        logic [31:0] dm;
        sm = mask_of(r.src_len);
        dm = mask_of(r.dst_len);
        if ((sa & sm) != (r.src & sm)) return 0;
        if ((da & dm) != (r.dst & dm)) return 0;
        if (dir != r.dir && r.dir != DIR_ANY && dir != DIR_ANY) return 0;
        if (cls != r.proto && r.proto != PROTO_ANY) return 0;
        if (cls == PROTO_TCP || cls == PROTO_UDP) begin
            if (!port_pass(sp, r.sport) || !port_pass(dp, r.dport)) return 0;
        end
        if (cls == PROTO_TCP) begin
            if (r.ack == ACK_SET && !ack) return 0;
            if (r.ack == ACK_CLEAR && ack) return 0;
        end
        return 1;
    endfunction

    // predict the verdict for an accepted item and update the rule table
    always @(posedge i_clk) begin
        t_verdict v;
        logic [8:0] cls;
        if (!i_rst_n) begin
            rule_count = 0;
            fw_on = 1'b1;
            verdict_q.delete();
        end else begin
            if (i_cfg_we) fw_on = i_cfg_wdata;
            if (i_valid && !i_stall_in) begin
                v = '0;
                case (t_op'(i_opcode))
                    OP_CLASSIFY: begin
                        cls = (i_protocol == PROTO_ICMP || i_protocol == PROTO_TCP ||
                               i_protocol == PROTO_UDP) ? i_protocol : PROTO_OTHR;
                        if (!fw_on) begin
                            v.rsn = RSN_INACTIVE;
                        end else if (cls == PROTO_TCP && i_tcp_flags[3:1] == 3'b111) begin
                            v.rsn = RSN_XMAS;
                        end else begin
                            v.rsn = RSN_NOMATCH;
                            for (int k = 0; k < rule_count; k++) begin
                                if (rule_hit(rule_table[k], i_direction, i_source_address,
                                             i_dest_address, cls, i_source_port,
                                             i_dest_port, i_tcp_flags[0])) begin
                                    v.acc = rule_table[k].act;
                                    v.rsn = RSN_MATCH;
                                    v.idx = 6'(k);
                                    break;
                                end
                            end
                        end
                    end
                    OP_APPEND: begin
                        if (rule_count >= RULE_SLOTS) begin
                            rule_count = 0;
                            v.rsn = RSN_FULL;
                        end else begin
                            rule_table[rule_count] = '{src: i_source_address,
                                dst: i_dest_address, src_len: i_source_prefix_len,
                                dst_len: i_dest_prefix_len, dir: i_direction,
                                proto: i_protocol, sport: i_source_port,
                                dport: i_dest_port, ack: i_ack_mode,
                                act: i_rule_accepts};
                            rule_count++;
                        end
                    end
                    OP_CLEAR: rule_count = 0;
                    default: ;
                endcase
                v.held = 7'(rule_count);
                verdict_q.push_back(v);
            end
        end
    end

    // compare each delivered result with the oldest prediction
    always @(posedge i_clk) begin
        t_verdict w;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else if (i_out_valid && !i_out_stall) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result acc=%0d rsn=%0d idx=%0d held=%0d",
                         $time, i_accept, i_reason, i_matched_rule, i_rules_held);
                o_fail_count <= o_fail_count + 1;
            end else begin
                w = verdict_q.pop_front();
                if (i_accept !== w.acc || i_reason !== w.rsn ||
                    i_matched_rule !== w.idx || i_rules_held !== w.held) begin
                    $display("%0t: mismatch exp acc=%0d rsn=%0d idx=%0d held=%0d",
                             $time, w.acc, w.rsn, w.idx, w.held);
                    $display("%0t:          got acc=%0d rsn=%0d idx=%0d held=%0d",
                             $time, i_accept, i_reason, i_matched_rule, i_rules_held);
                    o_fail_count <= o_fail_count + 1;
                end
            end
        end
    end

endmodule

/* tb/sv/first_match_packet_rule_classifier_unit_tb.sv */
`timescale 1ns / 1ps
module first_match_packet_rule_classifier_unit_tb import fcls_pkg::*;;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_opcode;
    logic [1:0]  i_direction;
    logic [31:0] i_source_address;
    logic [31:0] i_dest_address;
    logic [5:0]  i_source_prefix_len;
    logic [5:0]  i_dest_prefix_len;
    logic [8:0]  i_protocol;
    logic [15:0] i_source_port;
    logic [15:0] i_dest_port;
    logic [3:0]  i_tcp_flags;
    logic [1:0]  i_ack_mode;
    logic        i_rule_accepts;
    logic        o_valid;
    logic        i_stall;
    logic        o_accept;
    logic [2:0]  o_reason;
    logic [5:0]  o_matched_rule;
    logic [6:0]  o_rules_held;

    int fail_count;
    int pending;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;

    first_match_packet_rule_classifier_unit u_top (.*);

    first_match_packet_rule_classifier_unit_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .i_stall_in(o_stall), .i_opcode(i_opcode),
        .i_direction(i_direction), .i_source_address(i_source_address),
        .i_dest_address(i_dest_address), .i_source_prefix_len(i_source_prefix_len),
        .i_dest_prefix_len(i_dest_prefix_len), .i_protocol(i_protocol),
        .i_source_port(i_source_port), .i_dest_port(i_dest_port),
        .i_tcp_flags(i_tcp_flags), .i_ack_mode(i_ack_mode),
        .i_rule_accepts(i_rule_accepts), .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_accept(o_accept), .i_reason(o_reason), .i_matched_rule(o_matched_rule),
        .i_rules_held(o_rules_held), .o_fail_count(fail_count), .o_pending(pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000) begin
            $display("first_match_packet_rule_classifier_unit_tb: errors");
            $finish;
        end
    end

    // receiver stalls at random
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // one item on the input channel, with optional idle cycles first
    task automatic send_item(logic [1:0] op, logic [1:0] dir, logic [31:0] sa,
                             logic [31:0] da, logic [5:0] sl, logic [5:0] dl,
                             logic [8:0] pr, logic [15:0] sp, logic [15:0] dp,
                             logic [3:0] fl, logic [1:0] am, logic act);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        i_valid <= 1'b1;
        i_opcode <= op;
        i_direction <= dir;
        i_source_address <= sa;
        i_dest_address <= da;
        i_source_prefix_len <= sl;
        i_dest_prefix_len <= dl;
        i_protocol <= pr;
        i_source_port <= sp;
        i_dest_port <= dp;
        i_tcp_flags <= fl;
        i_ack_mode <= am;
        i_rule_accepts <= act;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        i_valid <= 1'b0;
        // the block stalls for at least this cycle after taking an item
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending != 0) @(posedge i_clk);
        repeat (RULE_SLOTS + 8) @(posedge i_clk);
    endtask

    task automatic write_active(logic val);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [8:0] pick_proto(logic is_rule);
        case ($urandom_range(is_rule ? 6 : 5))
            0: return PROTO_TCP;
            1: return PROTO_TCP;
            2: return PROTO_UDP;
            3: return PROTO_ICMP;
            4: return is_rule ? PROTO_ANY : 9'($urandom_range(511));
            5: return is_rule ? PROTO_OTHR : 9'($urandom_range(255));
            default: return 9'($urandom_range(511));
        endcase
    endfunction

    function automatic logic [15:0] pick_port(logic is_rule);
        case ($urandom_range(4))
            0: return is_rule ? PORT_WILD : 16'($urandom_range(65535));
            1: return is_rule ? PORT_HIGH : 16'($urandom_range(65535, 1024));
            2: return 16'($urandom_range(3, 1));
            3: return 16'($urandom_range(65535));
            default: return 16'($urandom_range(1023));
        endcase
    endfunction

    // random mix: rules near a small address pool so packets hit often
    task automatic random_items(int n);
        logic [31:0] base_s;
        logic [31:0] base_d;
        logic [3:0]  op_pick;
        logic        is_rule;
        base_s = 32'h0a000000;
        base_d = 32'hc0a80100;
        for (int k = 0; k < n; k++) begin
            op_pick = 4'($urandom_range(15));
            is_rule = (op_pick < 6);
            send_item(op_pick < 6 ? OP_APPEND : (op_pick == 6 ? OP_CLEAR :
                      (op_pick == 7 && $urandom_range(3) == 0 ? OP_NONE : OP_CLASSIFY)),
                      2'($urandom_range(3)),
                      $urandom_range(2) == 0 ? $urandom() : base_s ^ 32'($urandom_range(3)),
                      $urandom_range(2) == 0 ? $urandom() : base_d ^ 32'($urandom_range(3)),
                      6'($urandom_range(2) == 0 ? $urandom_range(63) : $urandom_range(32)),
                      6'($urandom_range(2) == 0 ? $urandom_range(63) : $urandom_range(32)),
                      pick_proto(is_rule), pick_port(is_rule), pick_port(is_rule),
                      4'($urandom_range(15)), 2'($urandom_range(3)), 1'($urandom_range(1)));
        end
    endtask

    // stimulus
    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        i_valid = 1'b0;
        i_opcode = OP_CLASSIFY;
        i_direction = '0;
        i_source_address = '0;
        i_dest_address = '0;
        i_source_prefix_len = '0;
        i_dest_prefix_len = '0;
        i_protocol = '0;
        i_source_port = '0;
        i_dest_port = '0;
        i_tcp_flags = '0;
        i_ack_mode = '0;
        i_rule_accepts = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, rules with extremes, xmas and non-tcp xmas
        send_item(OP_CLASSIFY, 0, 0, 0, 0, 0, PROTO_TCP, 0, 0, 0, 0, 0);
        send_item(OP_APPEND, 1, 32'hffffffff, 32'hffffffff, 6'd63, 6'd32, PROTO_TCP,
                  16'd1023, 16'd2000, 0, ACK_SET, 1);
        send_item(OP_APPEND, 3, 32'h0a000000, 0, 6'd8, 0, PROTO_UDP, PORT_HIGH, 0, 0,
                  ACK_CLEAR, 1);
        send_item(OP_APPEND, DIR_ANY, 0, 0, 0, 0, PROTO_OTHR, 0, 0, 0, 2'd3, 0);
        send_item(OP_APPEND, 0, 0, 0, 0, 0, 9'd99, 0, 0, 0, 0, 1);
        send_item(OP_APPEND, 0, 0, 0, 0, 0, PROTO_ANY, 0, 0, 0, ACK_CLEAR, 1);
        send_item(OP_CLASSIFY, 1, 32'hffffffff, 32'hffffffff, 0, 0, PROTO_TCP,
                  16'd1023, 16'd2000, 4'h1, 0, 0);
        send_item(OP_CLASSIFY, 1, 32'hffffffff, 32'hffffffff, 0, 0, PROTO_TCP,
                  16'd1023, 16'd2000, 4'h0, 0, 0);
        send_item(OP_CLASSIFY, 3, 32'h0a123456, 0, 0, 0, PROTO_UDP, 16'hffff, 0, 0, 0, 0);
        send_item(OP_CLASSIFY, 3, 0, 0, 0, 0, 9'd511, 0, 0, 0, 0, 0);
        send_item(OP_CLASSIFY, 0, 0, 0, 0, 0, PROTO_TCP, 0, 0, 4'hf, 0, 0);
        send_item(OP_CLASSIFY, 0, 0, 0, 0, 0, PROTO_ICMP, 0, 0, 4'he, 0, 0);
        send_item(OP_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_CLASSIFY, 0, 0, 0, 0, 0, PROTO_ICMP, 0, 0, 0, 0, 0);
        // fill the table and overflow it
        for (int k = 0; k < RULE_SLOTS + 1; k++)
            send_item(OP_APPEND, 1, 0, 0, 6'd32, 0, PROTO_ANY, 0, 0, 0, 0, k[0]);
        write_active(1'b0);
        send_item(OP_CLASSIFY, 1, 0, 0, 0, 0, PROTO_UDP, 0, 0, 0, 0, 0);

        // random phases with different idling and activity settings
        send_idle_pct = 38;
        recv_idle_pct = 69;
        random_items(100);
        write_active(1'b1);
        random_items(200);
        // sender holds off until everything has come back
        while (pending != 0) @(posedge i_clk);
        send_idle_pct = 69;
        recv_idle_pct = 38;
        random_items(250);
        write_active(1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_items(50);
        write_active(1'b1);
        random_items(300);

        wait_drained();
        if (fail_count == 0) begin
            $display("first_match_packet_rule_classifier_unit_tb: clean");
        end else begin
            $display("first_match_packet_rule_classifier_unit_tb: errors");
        end
        $finish;
    end

endmodule
